// ===== rtl/btsq_pkg.sv =====
// Shared types, constants and widths for the batch ticket shift queue.
// No dependencies; btsq_out, btsq_ctrl, the top level, the checker and the testbench import it.
package btsq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int GS_W     = 8;
    localparam int OCC_W    = 5;
    localparam int TICKET_W = 32;

    // Compare width for group size against counts
    localparam int CMP_W = (CNT_W > GS_W) ? CNT_W : GS_W;

    // Stream widths
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = CMD_W;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 1;

    // Command codes carried on s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_REPORT = 2'd2
    } cmd_t;

    // One result transaction
    typedef struct packed {
        logic                overflow;
        logic                underflow;
        logic [OCC_W-1:0]    occupancy;
        logic                entry_valid;
        logic [TICKET_W-1:0] ticket;
        logic                last;
    } out_item_t;

endpackage

// ===== rtl/btsq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents have no reset.
module btsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/btsq_out.sv =====
// Output register stage for the result stream: decouples the sequencer
// from m_tready. Depends on btsq_pkg.
module btsq_out (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  btsq_pkg::out_item_t                    in_item,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [btsq_pkg::M_DATA_W-1:0]          m_tdata,  // overflow, underflow, occupancy[4:0], ticket[31:0], pad
    output logic [btsq_pkg::M_USER_W-1:0]          m_tuser,  // entry_valid
    output logic                                   m_tlast
);
    import btsq_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Slot is free when empty or being drained this cycle
    assign in_ready   = !valid_reg || m_tready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    // Pack fields from bit 0 up
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, item_reg.ticket, item_reg.occupancy,
                       item_reg.underflow, item_reg.overflow};
    assign m_tuser  = item_reg.entry_valid;
    assign m_tlast  = item_reg.last;

endmodule

// ===== rtl/btsq_ctrl.sv =====
// Command sequencer: keeps head/tail/count and the ticket counter, writes
// pushed tickets into the entry RAM and walks it for reports. Depends on btsq_pkg.
module btsq_ctrl (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [btsq_pkg::S_DATA_W-1:0]          s_tdata,
    input  logic [btsq_pkg::S_USER_W-1:0]          s_tuser,
    output logic                                   ram_we,
    output logic [btsq_pkg::PTR_W-1:0]             ram_waddr,
    output logic [btsq_pkg::TICKET_W-1:0]          ram_wdata,
    output logic                                   ram_re,
    output logic [btsq_pkg::PTR_W-1:0]             ram_raddr,
    input  logic [btsq_pkg::TICKET_W-1:0]          ram_rdata,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output btsq_pkg::out_item_t                    out_item
);
    import btsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_REPORT_RD,
        ST_REPORT_EMIT,
        ST_RESULT
    } state_t;

    state_t                state_reg,   state_next;
    logic [PTR_W-1:0]      head_reg,    head_next;
    logic [PTR_W-1:0]      tail_reg,    tail_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [TICKET_W-1:0]   counter_reg, counter_next;
    logic [CNT_W-1:0]      fit_reg,     fit_next;
    logic [GS_W-1:0]       skip_reg,    skip_next;
    logic [PTR_W-1:0]      rd_ptr_reg,  rd_ptr_next;
    logic [CNT_W-1:0]      rem_reg,     rem_next;
    logic                  ovf_reg,     ovf_next;
    logic                  unf_reg,     unf_next;

    logic [GS_W-1:0]       gs;
    logic [CNT_W-1:0]      room;
    logic [CMP_W-1:0]      n_ext;
    logic [CMP_W-1:0]      room_ext;
    logic [CNT_W-1:0]      fit;
    logic [PTR_W:0]        head_sum;
    logic [TICKET_W-1:0]   ticket_inc;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign gs       = s_tdata[GS_W-1:0];

    // Push sizing: how many arrivals fit, how many tickets are skipped
    assign room     = CNT_W'(QUEUE_DEPTH) - count_reg;
    assign n_ext    = CMP_W'(gs);
    assign room_ext = CMP_W'(room);
    assign fit      = (n_ext < room_ext) ? CNT_W'(n_ext) : CNT_W'(room_ext);

    // Head advance on remove; sum stays below twice the depth
    assign head_sum   = (PTR_W+1)'(head_reg) + (PTR_W+1)'(gs);
    assign ticket_inc = counter_reg + TICKET_W'(1);

    // Next-state logic
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        fit_next     = fit_reg;
        skip_next    = skip_reg;
        rd_ptr_next  = rd_ptr_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        unf_next     = unf_reg;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = ticket_inc;
        ram_re    = 1'b0;
        ram_raddr = rd_ptr_reg;

        out_valid            = 1'b0;
        out_item.overflow    = 1'b0;
        out_item.underflow   = 1'b0;
        out_item.occupancy   = OCC_W'(count_reg);
        out_item.entry_valid = 1'b0;
        out_item.ticket      = '0;
        out_item.last        = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ovf_next  = 1'b0;
                    unf_next  = 1'b0;
                    skip_next = '0;
                    case (cmd_t'(s_tuser))
                        CMD_PUSH: begin
                            fit_next  = fit;
                            skip_next = GS_W'(n_ext - CMP_W'(fit));
                            ovf_next  = (n_ext > CMP_W'(fit));
                            state_next = (fit == '0) ? ST_RESULT : ST_PUSH;
                        end
                        CMD_REMOVE: begin
                            if (n_ext > CMP_W'(count_reg)) begin
                                unf_next   = 1'b1;
                                count_next = '0;
                                head_next  = tail_reg;
                            end else begin
                                count_next = count_reg - CNT_W'(gs);
                                if (head_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
                                    head_next = PTR_W'(head_sum - (PTR_W+1)'(QUEUE_DEPTH));
                                end else begin
                                    head_next = PTR_W'(head_sum);
                                end
                            end
                            state_next = ST_RESULT;
                        end
                        CMD_REPORT: begin
                            rd_ptr_next = head_reg;
                            rem_next    = count_reg;
                            state_next  = (count_reg == '0) ? ST_RESULT : ST_REPORT_RD;
                        end
                        default: begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // One ticket written per cycle at the tail
            ST_PUSH: begin
                ram_we       = 1'b1;
                counter_next = ticket_inc;
                tail_next    = ptr_inc(tail_reg);
                count_next   = count_reg + CNT_W'(1);
                fit_next     = fit_reg - CNT_W'(1);
                if (fit_reg == CNT_W'(1)) begin
                    state_next = ST_RESULT;
                end
            end

            // First read of a report walk
            ST_REPORT_RD: begin
                ram_re      = 1'b1;
                rd_ptr_next = ptr_inc(rd_ptr_reg);
                state_next  = ST_REPORT_EMIT;
            end

            // Present read data; on acceptance fetch the next entry
            ST_REPORT_EMIT: begin
                out_valid            = 1'b1;
                out_item.entry_valid = 1'b1;
                out_item.ticket      = ram_rdata;
                out_item.last        = (rem_reg == CNT_W'(1));
                if (out_ready) begin
                    rem_next = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_re      = 1'b1;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end
                end
            end

            // Single status result; skipped tickets are charged here
            ST_RESULT: begin
                out_valid          = 1'b1;
                out_item.overflow  = ovf_reg;
                out_item.underflow = unf_reg;
                if (out_ready) begin
                    counter_next = counter_reg + TICKET_W'(skip_reg);
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            counter_reg <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            counter_reg <= counter_next;
        end
        fit_reg    <= fit_next;
        skip_reg   <= skip_next;
        rd_ptr_reg <= rd_ptr_next;
        rem_reg    <= rem_next;
        ovf_reg    <= ovf_next;
        unf_reg    <= unf_next;
    end

endmodule

// ===== rtl/batch_ticket_shift_queue_core.sv =====
// Top level of the batch ticket shift queue: entry RAM, command sequencer
// and result register. Depends on btsq_pkg, btsq_ram, btsq_ctrl, btsq_out.
//
//  Channel  | Dir | tdata                                       | tuser        | tlast
//  ---------+-----+---------------------------------------------+--------------+------
//  s_       | in  | group_size[7:0]                             | command[1:0] | -
//  m_       | out | ovf, unf, occupancy[4:0], ticket[31:0], pad | entry_valid  | last
//
//  Entries live in a circular buffer in one RAM (head, tail, count), so a
//  remove only moves the head and the count. Push: one RAM write per fitted
//  ticket, then the status result. Report: one result per cycle after the
//  first RAM read unless m_tready stalls it. Remove and other codes: status only.
//  Reset clears count, pointers and ticket counter at once; no clearing pass.
//  m_tready low stalls the sequencer; s_tready is high whenever it is idle.
module batch_ticket_shift_queue_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [btsq_pkg::S_DATA_W-1:0]          s_tdata,  // group_size[7:0]
    input  logic [btsq_pkg::S_USER_W-1:0]          s_tuser,  // command[1:0]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [btsq_pkg::M_DATA_W-1:0]          m_tdata,  // overflow, underflow, occupancy[4:0], ticket[31:0], pad
    output logic [btsq_pkg::M_USER_W-1:0]          m_tuser,  // entry_valid
    output logic                                   m_tlast
);
    import btsq_pkg::*;

    logic                ram_we;
    logic [PTR_W-1:0]    ram_waddr;
    logic [TICKET_W-1:0] ram_wdata;
    logic                ram_re;
    logic [PTR_W-1:0]    ram_raddr;
    logic [TICKET_W-1:0] ram_rdata;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_item;

    // Entry storage; writes only in push, reads only in report, never overlapping
    btsq_ram #(
        .WIDTH (TICKET_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Command sequencer
    btsq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Result register
    btsq_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (out_valid),
        .in_ready (out_ready),
        .in_item  (out_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/btsq_checker.sv =====
// Port-level checks on the result stream of the batch ticket shift queue,
// bound to the top level. Depends on btsq_pkg and batch_ticket_shift_queue_core.
module btsq_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic [btsq_pkg::M_DATA_W-1:0]          m_tdata,  // overflow, underflow, occupancy[4:0], ticket[31:0], pad
    input  logic [btsq_pkg::M_USER_W-1:0]          m_tuser,  // entry_valid
    input  logic                                   m_tlast
);
    import btsq_pkg::*;

    // Result register empties on reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result is not withdrawn
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Status results carry no ticket and close their command
    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[38:7] == 32'd0) && m_tlast)
        else $error("status result with ticket or without last");

    // Listed entries never carry a flag
    a_entry_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[1:0] == 2'b00))
        else $error("listed entry with flag set");

    // Overflow and underflow never together
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("overflow and underflow both set");

endmodule

bind batch_ticket_shift_queue_core btsq_checker u_btsq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for batch_ticket_shift_queue_core: push, remove and report
// transactions are checked against a behavioral queue model kept in this file.
// Depends on btsq_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_top;
    import btsq_pkg::*;

    // One command as it travels on the input channel
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [GS_W-1:0]  size;
    } command_item_t;

    localparam int DRAIN_CYCLES = QUEUE_DEPTH + 24;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    // Stimulus and model state
    command_item_t pending_cmds[$];
    out_item_t     expected_results[$];
    logic [31:0]   held_tickets[$];
    bit   [31:0]   ticket_count   = '0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            queued_cnt     = 0;
    int            accepted_cnt   = 0;
    int            result_cnt     = 0;
    int            overflow_cnt   = 0;
    int            underflow_cnt  = 0;
    int            report_cnt     = 0;
    int            error_cnt      = 0;

    batch_ticket_shift_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Queue model: updates held tickets and ticket counter, queues expected results
    function automatic void apply_command(input logic [CMD_W-1:0] code,
                                          input logic [GS_W-1:0] n);
        out_item_t r;
        int        room;
        int        fit;
        r      = '0;
        r.last = 1'b1;
        case (code)
            CMD_PUSH: begin
                room = QUEUE_DEPTH - held_tickets.size();
                fit  = (int'(n) < room) ? int'(n) : room;
                for (int i = 0; i < fit; i++) begin
                    ticket_count = ticket_count + 1;
                    held_tickets.push_back(ticket_count);
                end
                // arrivals that did not fit still burn their ticket numbers
                ticket_count = ticket_count + 32'(int'(n) - fit);
                r.overflow   = (int'(n) > fit);
                r.occupancy  = OCC_W'(held_tickets.size());
                if (r.overflow) overflow_cnt++;
                expected_results.push_back(r);
            end
            CMD_REMOVE: begin
                if (int'(n) > held_tickets.size()) begin
                    held_tickets.delete();
                    r.underflow = 1'b1;
                    underflow_cnt++;
                end else begin
                    repeat (int'(n)) void'(held_tickets.pop_front());
                end
                r.occupancy = OCC_W'(held_tickets.size());
                expected_results.push_back(r);
            end
            CMD_REPORT: begin
                report_cnt++;
                if (held_tickets.size() == 0) begin
                    expected_results.push_back(r);
                end else begin
                    foreach (held_tickets[i]) begin
                        r.occupancy   = OCC_W'(held_tickets.size());
                        r.entry_valid = 1'b1;
                        r.ticket      = held_tickets[i];
                        r.last        = (i == held_tickets.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: begin
                // unknown code: one empty result, state untouched
                r.occupancy = OCC_W'(held_tickets.size());
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // Driver: loads the next command whenever the channel is free
    always @(posedge aclk) begin
        command_item_t c;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                apply_command(s_tuser, s_tdata);
                accepted_cnt++;
            end
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= c.cmd;
                s_tdata  <= c.size;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: each result transaction against the oldest expectation
    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.overflow    = m_tdata[0];
            got.underflow   = m_tdata[1];
            got.occupancy   = m_tdata[6:2];
            got.ticket      = m_tdata[38:7];
            got.entry_valid = m_tuser[0];
            got.last        = m_tlast;
            result_cnt++;
            if (expected_results.size() == 0) begin
                error_cnt++;
                if (error_cnt <= 10)
                    $display("%0t: unexpected result ovf=%0b unf=%0b occ=%0d ev=%0b tk=%0d last=%0b",
                             $realtime, got.overflow, got.underflow, got.occupancy,
                             got.entry_valid, got.ticket, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got.overflow !== want.overflow || got.underflow !== want.underflow ||
                    got.occupancy !== want.occupancy || got.entry_valid !== want.entry_valid ||
                    got.ticket !== want.ticket || got.last !== want.last) begin
                    error_cnt++;
                    if (error_cnt <= 10) begin
                        $display("%0t: mismatch on result %0d", $realtime, result_cnt);
                        $display("  exp ovf=%0b unf=%0b occ=%0d ev=%0b tk=%0d last=%0b",
                                 want.overflow, want.underflow, want.occupancy,
                                 want.entry_valid, want.ticket, want.last);
                        $display("  got ovf=%0b unf=%0b occ=%0d ev=%0b tk=%0d last=%0b",
                                 got.overflow, got.underflow, got.occupancy,
                                 got.entry_valid, got.ticket, got.last);
                    end
                end
            end
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int size);
        command_item_t c;
        c.cmd  = cmd;
        c.size = GS_W'(size);
        pending_cmds.push_back(c);
        queued_cnt++;
    endtask

    // Random traffic: mostly small groups with frequent reports
    task automatic queue_random(input int count);
        int roll;
        int pick;
        int size;
        repeat (count) begin
            roll = $urandom_range(99);
            pick = $urandom_range(99);
            if (pick < 70)      size = $urandom_range(1, 8);
            else if (pick < 90) size = $urandom_range(9, 20);
            else if (pick < 97) size = $urandom_range(0, 255);
            else                size = 0;
            if (roll < 40)      queue_cmd(CMD_PUSH, size);
            else if (roll < 70) queue_cmd(CMD_REMOVE, size);
            else if (roll < 96) queue_cmd(CMD_REPORT, size);
            else                queue_cmd(2'd3, size);
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queue_random(count);
        wait_idle();
    endtask

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed corner cases
        queue_cmd(CMD_PUSH, 0);       // zero group: no tickets consumed
        queue_cmd(CMD_REPORT, 0);     // report on empty queue
        queue_cmd(CMD_REMOVE, 0);
        queue_cmd(CMD_REMOVE, 1);     // underflow on empty
        queue_cmd(CMD_PUSH, 1);
        queue_cmd(CMD_REPORT, 7);
        queue_cmd(CMD_PUSH, 255);     // fill up, overflow burns the rest
        queue_cmd(CMD_REPORT, 255);   // full report
        queue_cmd(CMD_PUSH, 1);       // push on full queue
        queue_cmd(CMD_REMOVE, 3);
        queue_cmd(CMD_REPORT, 0);
        queue_cmd(CMD_REMOVE, 13);    // exact removal, no underflow
        queue_cmd(CMD_REPORT, 0);
        queue_cmd(CMD_PUSH, 16);      // exact fill
        queue_cmd(CMD_REMOVE, 255);   // underflow on full queue
        queue_cmd(2'd3, 170);         // unknown code
        queue_cmd(CMD_PUSH, 5);
        queue_cmd(CMD_REMOVE, 2);
        queue_cmd(CMD_REPORT, 85);
        queue_cmd(2'd3, 0);
        wait_idle();

        run_phase(0, 0, 90);
        run_phase(50, 0, 87);
        run_phase(0, 50, 87);
        run_phase(15, 15, 87);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            error_cnt += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end

        $display("Ran %0d commands (%0d reports), checked %0d results, %0d mismatches.",
                 accepted_cnt, report_cnt, result_cnt, error_cnt);
        $display("Saw %0d overflowing pushes and %0d underflowing removes.",
                 overflow_cnt, underflow_cnt);
        if (error_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
